// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sbcf_pkg.sv =====
// Shared types and constants for the servo bus command framer.
// No dependencies.
package sbcf_pkg;

	localparam int MAX_SERVO_ID_DEF = 4;
	localparam int FQ_DEPTH = 2;

	// Packet byte values
	localparam logic [7:0] HDR0       = 8'h12;
	localparam logic [7:0] HDR1       = 8'h4C;
	localparam logic [7:0] BCAST_ID   = 8'hFF;
	localparam logic [7:0] CODE_PING  = 8'h01;
	localparam logic [7:0] CODE_READ  = 8'h0A;
	localparam logic [7:0] CODE_DAMP  = 8'h09;
	localparam logic [7:0] CODE_ANGLE = 8'h08;
	localparam logic [7:0] LEN_SHORT  = 8'h01;
	localparam logic [7:0] LEN_DAMP   = 8'h03;
	localparam logic [7:0] LEN_ANGLE  = 8'h07;

	// Byte positions inside a packet
	localparam int IDX_W = 4;
	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t POS_HDR0   = 4'd0;
	localparam idx_t POS_HDR1   = 4'd1;
	localparam idx_t POS_CODE   = 4'd2;
	localparam idx_t POS_LEN    = 4'd3;
	localparam idx_t POS_ID     = 4'd4;
	localparam idx_t POS_PL0    = 4'd5;
	localparam idx_t POS_PL1    = 4'd6;
	localparam idx_t POS_PL2    = 4'd7;
	localparam idx_t POS_PL3    = 4'd8;
	localparam idx_t POS_PL4    = 4'd9;
	localparam idx_t POS_PL5    = 4'd10;
	localparam idx_t LAST_SHORT = 4'd5;
	localparam idx_t LAST_DAMP  = 4'd7;
	localparam idx_t LAST_ANGLE = 4'd11;

	typedef enum logic [1:0] {
		OP_PING,
		OP_READ,
		OP_DAMP,
		OP_ANGLE
	} op_t;

	// Classified command, one queue entry
	typedef struct packed {
		logic [7:0]  code;
		logic [7:0]  len;
		logic [7:0]  id;
		logic [47:0] payload;
		idx_t        last_pos;
	} cmd_t;

	// Queue status toward both ends
	typedef struct packed {
		logic full;
		logic empty;
	} fq_stat_t;

endpackage

// ===== hw/rtl/servo_bus_command_framer.sv =====
// Servo bus command framer: request in, packet bytes out, one byte per cycle while pop is held and commands are queued.
// Path: request registered in the front stage, queued as a descriptor, then each byte registered at the output.
// Packets are 6, 8 or 12 bytes (ping/read, damping, angle), emitted by the byte
// serializer one packet byte per cycle while the output is popped.
// Reset: asynchronous, clears all valid flags, queue pointers and byte position.
// Depends on sbcf_pkg, sbcf_front, sbcf_queue, sbcf_back, assert_macros.svh.
`include "assert_macros.svh"

module servo_bus_command_framer #(
	parameter int MAX_SERVO_ID = sbcf_pkg::MAX_SERVO_ID_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [7:0]         servo_id,
	input  logic signed [15:0] target_angle,
	input  logic [15:0]        move_interval,
	input  logic [15:0]        drive_power,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         tx_byte,
	output logic               last_byte
);
	import sbcf_pkg::*;

	fq_stat_t fq_stat;
	cmd_t     fq_wdata;
	cmd_t     fq_rdata;
	logic     fq_push;
	logic     fq_pop;

	// Request classification
	sbcf_front #(
		.MAX_SERVO_ID(MAX_SERVO_ID)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.servo_id     (servo_id),
		.target_angle (target_angle),
		.move_interval(move_interval),
		.drive_power  (drive_power),
		.fq_stat      (fq_stat),
		.fq_push      (fq_push),
		.fq_wdata     (fq_wdata)
	);

	// Descriptor queue
	sbcf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fq_push),
		.wr_data(fq_wdata),
		.rd_en  (fq_pop),
		.rd_data(fq_rdata),
		.stat   (fq_stat)
	);

	// Byte serializer
	sbcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (fq_rdata),
		.fq_stat  (fq_stat),
		.fq_pop   (fq_pop),
		.empty    (empty),
		.pop      (pop),
		.tx_byte  (tx_byte),
		.last_byte(last_byte)
	);

	// Internal checks
	`ASSERT_NEVER(a_fq_overflow, clk, arst_n, fq_push && fq_stat.full, "queue write while full")
	`ASSERT_NEVER(a_fq_underflow, clk, arst_n, fq_pop && fq_stat.empty, "queue read while empty")
	`ASSERT_NEXT(a_hdr_after_last, clk, arst_n, !empty && pop && last_byte, empty || (tx_byte == HDR0), "packet does not start with header")

endmodule

// ===== hw/rtl/sbcf_front.sv =====
// Front end: accepts command requests, classifies them into packet descriptors.
// Depends on sbcf_pkg; feeds sbcf_queue.
module sbcf_front #(
	parameter int MAX_SERVO_ID = sbcf_pkg::MAX_SERVO_ID_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [7:0]         servo_id,
	input  logic signed [15:0] target_angle,
	input  logic [15:0]        move_interval,
	input  logic [15:0]        drive_power,
	input  sbcf_pkg::fq_stat_t fq_stat,
	output logic               fq_push,
	output sbcf_pkg::cmd_t     fq_wdata
);
	import sbcf_pkg::*;

	localparam logic [7:0] MAX_ID = 8'(MAX_SERVO_ID);

	logic  valid_s1;
	cmd_t  cmd_s1;
	cmd_t  cmd_nxt;
	logic  accept;
	logic  id_ok;
	logic [7:0] id_pick;

	// Handshake: hold one request while the queue is full
	assign full    = valid_s1 && fq_stat.full;
	assign fq_push = valid_s1 && !fq_stat.full;
	assign accept  = push && !full;
	assign fq_wdata = cmd_s1;

	// Id range check, broadcast outside 1..MAX
	assign id_ok   = (servo_id != 8'd0) && (servo_id <= MAX_ID);
	assign id_pick = id_ok ? servo_id : BCAST_ID;

	// Classify the operation
	always_comb begin
		cmd_nxt = '0;
		case (op_t'(operation))
			OP_PING: begin
				cmd_nxt.code     = CODE_PING;
				cmd_nxt.len      = LEN_SHORT;
				cmd_nxt.id       = id_pick;
				cmd_nxt.last_pos = LAST_SHORT;
			end
			OP_READ: begin
				cmd_nxt.code     = CODE_READ;
				cmd_nxt.len      = LEN_SHORT;
				cmd_nxt.id       = id_pick;
				cmd_nxt.last_pos = LAST_SHORT;
			end
			OP_DAMP: begin
				cmd_nxt.code     = CODE_DAMP;
				cmd_nxt.len      = LEN_DAMP;
				cmd_nxt.id       = servo_id;
				cmd_nxt.payload  = {32'h0, drive_power};
				cmd_nxt.last_pos = LAST_DAMP;
			end
			OP_ANGLE: begin
				cmd_nxt.code     = CODE_ANGLE;
				cmd_nxt.len      = LEN_ANGLE;
				cmd_nxt.id       = id_pick;
				cmd_nxt.payload  = {drive_power, move_interval, target_angle};
				cmd_nxt.last_pos = LAST_ANGLE;
			end
			default: begin
				cmd_nxt = '0;
			end
		endcase
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fq_push);
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_nxt;
		end
	end

endmodule

// ===== hw/rtl/sbcf_queue.sv =====
// Short descriptor queue between the front end and the byte serializer.
// Depends on sbcf_pkg.
module sbcf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  sbcf_pkg::cmd_t     wr_data,
	input  logic               rd_en,
	output sbcf_pkg::cmd_t     rd_data,
	output sbcf_pkg::fq_stat_t stat
);
	import sbcf_pkg::*;

	localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(FQ_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FQ_DEPTH - 1);

	cmd_t             mem_q [FQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(FQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sbcf_back.sv =====
// Back end: walks a descriptor byte by byte, keeps the running checksum.
// Depends on sbcf_pkg; reads from sbcf_queue.
module sbcf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sbcf_pkg::cmd_t     cmd,
	input  sbcf_pkg::fq_stat_t fq_stat,
	output logic               fq_pop,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         tx_byte,
	output logic               last_byte
);
	import sbcf_pkg::*;

	idx_t       idx_q;
	logic [7:0] sum_q;
	logic       ovalid_q;
	logic [7:0] tx_byte_q;
	logic       last_q;
	logic       advance;
	logic       have;
	logic       at_last;
	logic [7:0] sel;

	assign empty     = !ovalid_q;
	assign tx_byte   = tx_byte_q;
	assign last_byte = last_q;

	// Output register moves when empty or being taken
	assign advance = !ovalid_q || pop;
	assign have    = !fq_stat.empty;
	assign at_last = (idx_q == cmd.last_pos);
	assign fq_pop  = advance && have && at_last;

	// Packet byte at the current position
	always_comb begin
		case (idx_q)
			POS_HDR0: sel = HDR0;
			POS_HDR1: sel = HDR1;
			POS_CODE: sel = cmd.code;
			POS_LEN:  sel = cmd.len;
			POS_ID:   sel = cmd.id;
			POS_PL0:  sel = cmd.payload[7:0];
			POS_PL1:  sel = cmd.payload[15:8];
			POS_PL2:  sel = cmd.payload[23:16];
			POS_PL3:  sel = cmd.payload[31:24];
			POS_PL4:  sel = cmd.payload[39:32];
			POS_PL5:  sel = cmd.payload[47:40];
			default:  sel = 8'h00;
		endcase
	end

	// Position, checksum and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			sum_q    <= '0;
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= have;
			if (have) begin
				if (at_last) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
					sum_q <= sum_q + sel;
				end
			end
		end
	end

	// Output data
	always_ff @(posedge clk) begin
		if (advance && have) begin
			tx_byte_q <= at_last ? sum_q : sel;
			last_q    <= at_last;
		end
	end

endmodule

// ===== test/tb_servo_bus_command_framer.sv =====
// Testbench for servo_bus_command_framer: drives command requests, checks packet bytes.
// A scoreboard class predicts every packet byte and compares the popped bytes in order.
// Depends on sbcf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_servo_bus_command_framer;
	import sbcf_pkg::*;

	localparam int MAX_ID = MAX_SERVO_ID_DEF;
	localparam int STALL_LIMIT = 500;
	localparam int RANDOM_REQUESTS = 360;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		op_t               op;
		logic [7:0]        id;
		logic signed [15:0] angle;
		logic [15:0]       interval;
		logic [15:0]       power;
	} servo_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} bus_byte_t;

	// Predicts packet bytes per request and checks them in arrival order
	class packet_scoreboard;
		bus_byte_t pending_bytes[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(servo_cmd_t c);
			logic [7:0] pkt[$];
			logic [7:0] dest;
			logic [7:0] sum;
			bus_byte_t  b;
			// out-of-range id goes to broadcast, except for damping
			dest = (c.id >= 1 && c.id <= MAX_ID) ? c.id : BCAST_ID;
			pkt.push_back(HDR0);
			pkt.push_back(HDR1);
			case (c.op)
				OP_PING: begin
					pkt.push_back(CODE_PING);
					pkt.push_back(LEN_SHORT);
					pkt.push_back(dest);
				end
				OP_READ: begin
					pkt.push_back(CODE_READ);
					pkt.push_back(LEN_SHORT);
					pkt.push_back(dest);
				end
				OP_DAMP: begin
					pkt.push_back(CODE_DAMP);
					pkt.push_back(LEN_DAMP);
					pkt.push_back(c.id);
					pkt.push_back(c.power[7:0]);
					pkt.push_back(c.power[15:8]);
				end
				default: begin
					pkt.push_back(CODE_ANGLE);
					pkt.push_back(LEN_ANGLE);
					pkt.push_back(dest);
					pkt.push_back(c.angle[7:0]);
					pkt.push_back(c.angle[15:8]);
					pkt.push_back(c.interval[7:0]);
					pkt.push_back(c.interval[15:8]);
					pkt.push_back(c.power[7:0]);
					pkt.push_back(c.power[15:8]);
				end
			endcase
			// 8-bit wrapping checksum over everything before it
			sum = 8'h00;
			foreach (pkt[k]) begin
				sum = sum + pkt[k];
				b.data = pkt[k];
				b.last = 1'b0;
				pending_bytes.push_back(b);
			end
			b.data = sum;
			b.last = 1'b1;
			pending_bytes.push_back(b);
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			bus_byte_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual tx_byte %h last_byte %b",
					$time, data, last);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (data !== want.data) begin
					$display("%0t: tx_byte mismatch: expected %h, actual %h",
						$time, want.data, data);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last_byte mismatch: expected %b, actual %b",
						$time, want.last, last);
					errors++;
				end
			end
		endfunction

		function int waiting();
			return pending_bytes.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [1:0]         operation;
	logic [7:0]         servo_id;
	logic signed [15:0] target_angle;
	logic [15:0]        move_interval;
	logic [15:0]        drive_power;
	logic               empty;
	logic               pop;
	logic [7:0]         tx_byte;
	logic               last_byte;

	packet_scoreboard sb;
	bit send_calm;
	bit recv_calm;
	int idle_cycles;

	servo_bus_command_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.servo_id     (servo_id),
		.target_angle (target_angle),
		.move_interval(move_interval),
		.drive_power  (drive_power),
		.empty        (empty),
		.pop          (pop),
		.tx_byte      (tx_byte),
		.last_byte    (last_byte)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap before the next request or pop; calm stretches have no gaps
	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// Field values biased toward the extremes
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [7:0] pick_id();
		if ($urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, MAX_ID + 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic servo_cmd_t make_cmd(op_t op, logic [7:0] id, logic [15:0] angle,
			logic [15:0] interval, logic [15:0] power);
		servo_cmd_t c;
		c.op = op;
		c.id = id;
		c.angle = angle;
		c.interval = interval;
		c.power = power;
		return c;
	endfunction

	// Present one request and hold it until the framer takes it
	task automatic send_request(servo_cmd_t c);
		int gap;
		gap = draw_gap(send_calm);
		if ($urandom_range(0, 19) == 0)
			send_calm = !send_calm;
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		operation = c.op;
		servo_id = c.id;
		target_angle = c.angle;
		move_interval = c.interval;
		drive_power = c.power;
		do @(posedge clk); while (full);
		sb.note_request(c);
	endtask

	// Byte sink with random stalls
	initial begin
		int gap;
		pop = 1'b0;
		recv_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(recv_calm);
			if ($urandom_range(0, 29) == 0)
				recv_calm = !recv_calm;
			@(negedge clk);
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			sb.check_byte(tx_byte, last_byte);
		end
	end

	// Watchdog: too long with no request or byte taken
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Main sequence
	initial begin
		sb = new();
		send_calm = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		operation = '0;
		servo_id = '0;
		target_angle = '0;
		move_interval = '0;
		drive_power = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every operation, id edges, field extremes
		send_request(make_cmd(OP_PING, 8'd1, 16'h1234, 16'h5678, 16'h9ABC));
		send_request(make_cmd(OP_PING, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_cmd(OP_PING, 8'(MAX_ID), 16'h0000, 16'h0000, 16'h0000));
		send_request(make_cmd(OP_PING, 8'(MAX_ID + 1), 16'h0000, 16'h0000, 16'h0000));
		send_request(make_cmd(OP_READ, 8'd2, 16'hAAAA, 16'h5555, 16'hFFFF));
		send_request(make_cmd(OP_READ, 8'd255, 16'h0000, 16'h0000, 16'h0000));
		send_request(make_cmd(OP_READ, 8'd0, 16'h8000, 16'h7FFF, 16'h0001));
		send_request(make_cmd(OP_READ, 8'(MAX_ID), 16'h0000, 16'h0000, 16'h0000));
		send_request(make_cmd(OP_DAMP, 8'd0, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_request(make_cmd(OP_DAMP, 8'd255, 16'h0000, 16'h0000, 16'hFFFF));
		send_request(make_cmd(OP_DAMP, 8'(MAX_ID + 1), 16'h1234, 16'h4321, 16'h00FF));
		send_request(make_cmd(OP_DAMP, 8'd3, 16'h0000, 16'h0000, 16'hFF00));
		send_request(make_cmd(OP_DAMP, 8'd128, 16'h0000, 16'h0000, 16'h8001));
		send_request(make_cmd(OP_ANGLE, 8'd1, 16'h8000, 16'h0000, 16'h0000));
		send_request(make_cmd(OP_ANGLE, 8'(MAX_ID), 16'h7FFF, 16'hFFFF, 16'hFFFF));
		send_request(make_cmd(OP_ANGLE, 8'd0, 16'hFFFF, 16'h0001, 16'h8000));
		send_request(make_cmd(OP_ANGLE, 8'd255, 16'h0000, 16'h8000, 16'h7FFF));
		send_request(make_cmd(OP_ANGLE, 8'(MAX_ID + 1), 16'h00FF, 16'hFF00, 16'h0F0F));
		send_request(make_cmd(OP_ANGLE, 8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(make_cmd(OP_ANGLE, 8'd3, 16'h0000, 16'h0000, 16'h0000));

		// random requests
		repeat (RANDOM_REQUESTS) begin
			send_request(make_cmd(op_t'($urandom_range(0, 3)), pick_id(), pick_word(),
				pick_word(), pick_word()));
		end
		@(negedge clk);
		push = 1'b0;

		// drain, then keep watching for stray bytes before the verdict
		while (sb.waiting() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sbcf_pkg.sv
hw/rtl/sbcf_front.sv
hw/rtl/sbcf_queue.sv
hw/rtl/sbcf_back.sv
hw/rtl/servo_bus_command_framer.sv
test/tb_servo_bus_command_framer.sv
